FILE: rtl/core/rset_pkg.sv
// Shared codes and control/status bundles for the randomized set table.
package rset_pkg;

    localparam int VALUE_W  = 32;
    localparam int RND_W    = 31;
    localparam int BITCNT_W = 5;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;
    localparam opcode_t OP_RANDOM = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_MISS  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    scan_step;
        logic    append;
        logic    rd_last;
        logic    move;
        logic    mod_start;
        logic    mod_step;
        logic    rd_pick;
        logic    publish;
        status_t pub_status;
        logic    pub_pick;
    } rset_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        opcode_t op;
        logic    empty;
        logic    full;
        logic    hit;
        logic    miss;
        logic    mod_done;
    } rset_sts_t;

endpackage

FILE: rtl/core/rset_req_if.sv
// Request channel: operation beat into the set table.
interface rset_req_if;
    import rset_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] value;
    logic [RND_W-1:0]          random_word;

    modport source (output valid, output opcode, output value, output random_word,
                    input ready);
    modport sink   (input valid, input opcode, input value, input random_word,
                    output ready);
endinterface

FILE: rtl/core/rset_rsp_if.sv
// Response channel: result beat out of the set table.
interface rset_rsp_if;
    import rset_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] picked_value;

    modport source (output valid, output status, output picked_value, input ready);
    modport sink   (input valid, input status, input picked_value, output ready);
endinterface

FILE: rtl/core/rset_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/rset_dp.sv
// Datapath: element store, live count, membership scan, remainder unit, result register.
module rset_dp import rset_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rset_cmd_t                 cmd,
    output rset_sts_t                 sts,
    input  logic [1:0]                opcode,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [RND_W-1:0]          random_word,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] picked_value
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    opcode_t          op_reg,        op_next;
    logic [VALUE_W-1:0] value_reg,   value_next;
    logic [RND_W-1:0] rnd_reg,       rnd_next;
    logic [CW-1:0]    count_reg,     count_next;
    logic [CW-1:0]    scan_idx_reg,  scan_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]    cmp_idx_reg,   cmp_idx_next;
    logic [CW-1:0]    rem_reg,       rem_next;
    logic [BITCNT_W-1:0] bits_left_reg, bits_left_next;
    status_t          status_reg,    status_next;
    logic [VALUE_W-1:0] picked_reg,  picked_next;

    logic               issue;
    logic [CW-1:0]      last_idx;
    logic [CW:0]        shifted;
    logic [CW:0]        count_ext;
    logic [CW:0]        diff;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    rset_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign issue     = cmd.scan_step && (scan_idx_reg < count_reg);
    assign last_idx  = count_reg - CW'(1);
    assign shifted   = {rem_reg, rnd_reg[RND_W-1]};
    assign count_ext = {1'b0, count_reg};
    assign diff      = shifted - count_ext;

    always_comb
    begin
        ram_re    = issue || cmd.rd_last || cmd.rd_pick;
        ram_raddr = scan_idx_reg[IW-1:0];
        if (cmd.rd_last)
        begin
            ram_raddr = last_idx[IW-1:0];
        end
        else if (cmd.rd_pick)
        begin
            ram_raddr = rem_reg[IW-1:0];
        end

        // Append goes to the first free slot; a move fills the hole with the last entry
        ram_we    = cmd.append || cmd.move;
        ram_waddr = cmd.move ? cmp_idx_reg : count_reg[IW-1:0];
        ram_wdata = cmd.move ? ram_rdata : value_reg;
    end

    always_comb
    begin
        op_next        = op_reg;
        value_next     = value_reg;
        rnd_next       = rnd_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        rem_next       = rem_reg;
        bits_left_next = bits_left_reg;
        status_next    = status_reg;
        picked_next    = picked_reg;

        if (cmd.load)
        begin
            op_next        = opcode;
            value_next     = value;
            rnd_next       = random_word;
            scan_idx_next  = '0;
            cmp_valid_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            cmp_valid_next = issue;
            if (issue)
            begin
                cmp_idx_next  = scan_idx_reg[IW-1:0];
                scan_idx_next = scan_idx_reg + CW'(1);
            end
        end

        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.move)
        begin
            count_next = last_idx;
        end

        if (cmd.mod_start)
        begin
            rem_next       = '0;
            bits_left_next = BITCNT_W'(RND_W);
        end
        else if (cmd.mod_step)
        begin
            // Restoring remainder: one bit of the random word per cycle, MSB first
            rem_next       = (shifted >= count_ext) ? diff[CW-1:0] : shifted[CW-1:0];
            rnd_next       = {rnd_reg[RND_W-2:0], 1'b0};
            bits_left_next = bits_left_reg - BITCNT_W'(1);
        end

        if (cmd.publish)
        begin
            status_next = cmd.pub_status;
            picked_next = cmd.pub_pick ? ram_rdata : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            bits_left_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            bits_left_reg <= bits_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        rnd_reg      <= rnd_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        rem_reg      <= rem_next;
        status_reg   <= status_next;
        picked_reg   <= picked_next;
    end

    assign sts.op       = op_reg;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg >= CAP_C);
    assign sts.hit      = cmp_valid_reg && (ram_rdata == value_reg);
    assign sts.miss     = !cmp_valid_reg && (scan_idx_reg >= count_reg);
    assign sts.mod_done = (bits_left_reg == '0);

    assign status       = status_reg;
    assign picked_value = picked_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("live count above capacity");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (count_reg < CAP_C) && !cmp_valid_reg)
        else $error("append into full store or during compare");

    a_move_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |-> (count_reg != '0) && $past(cmd.rd_last))
        else $error("move without a preceding last-entry read");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_pick |-> rem_reg < count_reg)
        else $error("random index outside live entries");
`endif

endmodule

FILE: rtl/core/rset_ctrl.sv
// Controller: sequences scan, update, remainder and result publication per operation.
module rset_ctrl import rset_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  rset_sts_t sts,
    output rset_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_RD_LAST  = 8'b0000_1000,
        S_MOVE     = 8'b0001_0000,
        S_MODULO   = 8'b0010_0000,
        S_RD_PICK  = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t  state_reg,      state_next;
    logic    out_valid_reg,  out_valid_next;
    status_t res_status_reg, res_status_next;
    logic    res_pick_reg,   res_pick_next;

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_pick_next   = res_pick_reg;
        cmd             = '0;
        in_ready        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_status_next = ST_OK;
                res_pick_next   = 1'b0;
                if (sts.op == OP_INSERT || sts.op == OP_REMOVE)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.op == OP_RANDOM)
                begin
                    if (sts.empty)
                    begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_MODULO;
                    end
                end
                else
                begin
                    // Unused opcode: report success, touch nothing
                    state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    if (sts.op == OP_INSERT)
                    begin
                        res_status_next = ST_MISS;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_RD_LAST;
                    end
                end
                else if (sts.miss)
                begin
                    state_next = S_RESULT;
                    if (sts.op == OP_REMOVE)
                    begin
                        res_status_next = ST_MISS;
                    end
                    else if (sts.full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RD_LAST:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = S_RESULT;
            end
            S_MODULO:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_RD_PICK;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_RD_PICK:
            begin
                cmd.rd_pick   = 1'b1;
                res_pick_next = 1'b1;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cmd.pub_status = res_status_reg;
        cmd.pub_pick   = res_pick_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_pick_reg   <= res_pick_next;
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result beat overwritten before it was taken");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted beat not dispatched");

    a_valid_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result beat raised outside publication");
`endif

endmodule

FILE: rtl/core/randomized_set_table_top.sv
// Top level of the randomized set table: channels, controller and datapath.
//
// Keeps up to CAPACITY distinct 32-bit values packed from slot 0, with insert,
// remove (the last entry fills the hole) and get-random (entry at
// random_word mod count). One operation is in flight at a time; the request
// channel is ready again once the result beat is loaded into the output
// register, which then waits for the sink without blocking the next request.
// Insert and remove scan the store one entry per cycle through the single
// registered read port, scanning all live entries when the value is absent;
// an insert that hits stops there, and a remove that hits then reads the last
// entry and moves it into the hole. Get-random runs a one-bit-per-cycle
// remainder over the 31-bit random word, then a store read; on an empty set
// it skips both and reports ST_EMPTY. The store needs no clearing after reset.
module randomized_set_table_top import rset_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    rset_req_if.sink  request,
    rset_rsp_if.source response
);

    rset_cmd_t cmd;
    rset_sts_t sts;

    rset_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rset_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (request.opcode),
        .value        (request.value),
        .random_word  (request.random_word),
        .status       (response.status),
        .picked_value (response.picked_value)
    );

endmodule
